FILE: rtl/core/ryc_pkg.sv
// Shared types, constants and conversion arithmetic for the RGB to YCbCr
// row-pair converter. No dependencies; used by the converter top level.
`default_nettype none

package ryc_pkg;

    // Field widths
    localparam int COMP_W        = 8;
    localparam int LINE_WIDTH_W  = 11;
    localparam int ACC_W         = 40;
    localparam int SHIFT_W       = 9;
    localparam int VAL_W         = 29;
    localparam int RECIP_SHIFT   = 50;
    localparam int PROD_W        = 59;
    localparam int REM_W         = 30;

    // Defaults
    localparam int MAX_WIDTH_DEF = 1024;
    localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 11'd640;

    // Weights over 1e9
    localparam logic signed [ACC_W-1:0] WY_R  =  40'sd256772628;
    localparam logic signed [ACC_W-1:0] WY_G  =  40'sd504096642;
    localparam logic signed [ACC_W-1:0] WY_B  =  40'sd97899984;
    localparam logic signed [ACC_W-1:0] WCR_R =  40'sd439186734;
    localparam logic signed [ACC_W-1:0] WCR_G = -40'sd367765524;
    localparam logic signed [ACC_W-1:0] WCR_B = -40'sd71421210;
    localparam logic signed [ACC_W-1:0] WCB_R = -40'sd148213170;
    localparam logic signed [ACC_W-1:0] WCB_G = -40'sd290973564;
    localparam logic signed [ACC_W-1:0] WCB_B =  40'sd439186734;

    localparam logic signed [ACC_W-1:0] LUMA_OFFSET   = 40'sd16000000000;
    localparam logic signed [ACC_W-1:0] CHROMA_OFFSET = 40'sd128000000000;
    localparam logic signed [ACC_W-1:0] ACC_SAT       = 40'sd255000000000;

    // 1e9 = 2^9 * 1953125; divide the shifted value by reciprocal multiply
    localparam logic [REM_W-1:0] DIV_D   = 30'd1953125;
    localparam logic [REM_W-1:0] DIV_INV = 30'd576460752;

    localparam logic [COMP_W-1:0] COMP_MAX = 8'd255;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [COMP_W-1:0] luma;
        logic              chroma_valid;
        logic [COMP_W-1:0] red_diff_avg;
        logic [COMP_W-1:0] blue_diff_avg;
        logic              row_end;
    } result_t;

    typedef struct packed {
        logic odd_row;
        logic row_end;
    } ctrl_t;

    typedef struct packed {
        logic              is_low;
        logic              is_high;
        logic [COMP_W-1:0] q_est;
        logic [VAL_W-1:0]  val;
    } quot_t;

    // Offset plus three constant products
    function automatic logic signed [ACC_W-1:0] weigh_sum(
        input pixel_t                  pix,
        input logic signed [ACC_W-1:0] w_r,
        input logic signed [ACC_W-1:0] w_g,
        input logic signed [ACC_W-1:0] w_b,
        input logic signed [ACC_W-1:0] offset
    );
        logic signed [ACC_W-1:0] r_ext;
        logic signed [ACC_W-1:0] g_ext;
        logic signed [ACC_W-1:0] b_ext;
        r_ext = $signed({{(ACC_W-COMP_W){1'b0}}, pix.red});
        g_ext = $signed({{(ACC_W-COMP_W){1'b0}}, pix.green});
        b_ext = $signed({{(ACC_W-COMP_W){1'b0}}, pix.blue});
        return offset + w_r * r_ext + w_g * g_ext + w_b * b_ext;
    endfunction

    // Saturation flags and quotient estimate, low by at most one
    function automatic quot_t estimate(input logic signed [ACC_W-1:0] acc);
        quot_t             q;
        logic [PROD_W-1:0] prod;
        q.is_low  = acc[ACC_W-1] || (acc == '0);
        q.is_high = (acc >= ACC_SAT);
        q.val     = acc[SHIFT_W+VAL_W-1:SHIFT_W];
        prod      = PROD_W'(q.val) * PROD_W'(DIV_INV);
        q.q_est   = prod[RECIP_SHIFT+COMP_W-1:RECIP_SHIFT];
        return q;
    endfunction

    // Correct the estimate and clamp to 0..255
    function automatic logic [COMP_W-1:0] finish(input quot_t q);
        logic [REM_W-1:0]  rem;
        logic [COMP_W-1:0] res;
        rem = REM_W'(q.val) - REM_W'(q.q_est) * DIV_D;
        res = (rem >= DIV_D) ? q.q_est + 8'd1 : q.q_est;
        if (q.is_low) begin
            res = '0;
        end else if (q.is_high) begin
            res = COMP_MAX;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ryc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ryc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and register the read data on a read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/rgb_to_ycbcr_row_pair_converter.sv
// One item per cycle sustained while out_ready is high, through the six-stage
// pipeline (capture, sum, estimate, correct, line buffer access,
// average/output). Stages compress over bubbles.
// Reset (rst_n low, async): pipeline empties, column and row parity clear,
// line_width returns to 640. The line buffer holds no reset value.
// Depends on ryc_pkg and ryc_ram.
`default_nettype none

module rgb_to_ycbcr_row_pair_converter #(
    parameter int MAX_WIDTH = ryc_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [ryc_pkg::LINE_WIDTH_W-1:0]     cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire ryc_pkg::pixel_t                      in_data,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output ryc_pkg::result_t                          out_data
);

    localparam int ADDR_W   = $clog2(MAX_WIDTH);
    localparam int CMP_W    = (ADDR_W + 1 > ryc_pkg::LINE_WIDTH_W) ? ADDR_W + 1
                                                                    : ryc_pkg::LINE_WIDTH_W;
    localparam int NSTAGE   = 6;
    localparam int CHROMA_W = 2 * ryc_pkg::COMP_W;

    // Configuration and row position
    logic [ryc_pkg::LINE_WIDTH_W-1:0] line_width_reg;
    logic [ADDR_W-1:0]                column_reg;
    logic [ADDR_W-1:0]                column_next;
    logic                             odd_row_reg;
    logic                             odd_row_next;
    logic [CMP_W-1:0]                 width_ext;
    logic [ADDR_W-1:0]                last_col;
    logic                             at_row_end;

    // Pipeline flow control
    logic [NSTAGE:1] stage_valid_reg;
    logic [NSTAGE:1] stage_valid_next;
    logic [NSTAGE:1] stage_free;
    logic [NSTAGE:1] stage_load;
    logic [NSTAGE:1] upstream_valid;

    // Stage payloads
    ryc_pkg::pixel_t               s1_pix_reg;
    ryc_pkg::ctrl_t                s1_ctrl_reg;
    logic [ADDR_W-1:0]             s1_slot_reg;
    logic signed [ryc_pkg::ACC_W-1:0] s2_acc_y_reg;
    logic signed [ryc_pkg::ACC_W-1:0] s2_acc_cr_reg;
    logic signed [ryc_pkg::ACC_W-1:0] s2_acc_cb_reg;
    ryc_pkg::ctrl_t                s2_ctrl_reg;
    logic [ADDR_W-1:0]             s2_slot_reg;
    ryc_pkg::quot_t                s3_q_y_reg;
    ryc_pkg::quot_t                s3_q_cr_reg;
    ryc_pkg::quot_t                s3_q_cb_reg;
    ryc_pkg::ctrl_t                s3_ctrl_reg;
    logic [ADDR_W-1:0]             s3_slot_reg;
    logic [ryc_pkg::COMP_W-1:0]    s4_y_reg;
    logic [ryc_pkg::COMP_W-1:0]    s4_cr_reg;
    logic [ryc_pkg::COMP_W-1:0]    s4_cb_reg;
    ryc_pkg::ctrl_t                s4_ctrl_reg;
    logic [ADDR_W-1:0]             s4_slot_reg;
    logic [ryc_pkg::COMP_W-1:0]    s5_y_reg;
    logic [ryc_pkg::COMP_W-1:0]    s5_cr_reg;
    logic [ryc_pkg::COMP_W-1:0]    s5_cb_reg;
    ryc_pkg::ctrl_t                s5_ctrl_reg;
    ryc_pkg::result_t              out_reg;
    ryc_pkg::result_t              out_next;

    // Line buffer access
    logic                 buf_wr_en;
    logic                 buf_rd_en;
    logic [CHROMA_W-1:0]  buf_rd_data;
    logic [ryc_pkg::COMP_W:0] cr_sum;
    logic [ryc_pkg::COMP_W:0] cb_sum;

    assign cfg_ready = 1'b1;

    // Last column of a row from the clamped width
    always_comb
    begin
        width_ext = CMP_W'(line_width_reg);
        if (width_ext == '0)
        begin
            last_col = '0;
        end
        else if (width_ext > CMP_W'(MAX_WIDTH))
        begin
            last_col = ADDR_W'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col = ADDR_W'(width_ext - CMP_W'(1));
        end
        at_row_end   = (column_reg >= last_col);
        column_next  = at_row_end ? '0 : column_reg + ADDR_W'(1);
        odd_row_next = at_row_end ? ~odd_row_reg : odd_row_reg;
    end

    // Stage handshakes: a stage takes an item when empty or when its item moves on
    always_comb
    begin
        upstream_valid = {stage_valid_reg[NSTAGE-1:1], in_valid};
        stage_free[NSTAGE] = !stage_valid_reg[NSTAGE] || out_ready;
        for (int i = NSTAGE - 1; i >= 1; i--)
        begin
            stage_free[i] = !stage_valid_reg[i] || stage_free[i+1];
        end
        stage_load       = stage_free & upstream_valid;
        stage_valid_next = (stage_free & upstream_valid) | (~stage_free & stage_valid_reg);
    end

    assign in_ready  = stage_free[1];
    assign out_valid = stage_valid_reg[NSTAGE];
    assign out_data  = out_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg  <= ryc_pkg::LINE_WIDTH_RESET;
            column_reg      <= '0;
            odd_row_reg     <= 1'b0;
            stage_valid_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                line_width_reg <= cfg_data;
            end
            if (stage_load[1])
            begin
                column_reg  <= column_next;
                odd_row_reg <= odd_row_next;
            end
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Capture the item with its row position
    always_ff @(posedge clk)
    begin
        if (stage_load[1])
        begin
            s1_pix_reg          <= in_data;
            s1_ctrl_reg.odd_row <= odd_row_reg;
            s1_ctrl_reg.row_end <= at_row_end;
            s1_slot_reg         <= column_reg;
        end
    end

    // Form the weighted sums
    always_ff @(posedge clk)
    begin
        if (stage_load[2])
        begin
            s2_acc_y_reg  <= ryc_pkg::weigh_sum(s1_pix_reg, ryc_pkg::WY_R, ryc_pkg::WY_G,
                                                ryc_pkg::WY_B, ryc_pkg::LUMA_OFFSET);
            s2_acc_cr_reg <= ryc_pkg::weigh_sum(s1_pix_reg, ryc_pkg::WCR_R, ryc_pkg::WCR_G,
                                                ryc_pkg::WCR_B, ryc_pkg::CHROMA_OFFSET);
            s2_acc_cb_reg <= ryc_pkg::weigh_sum(s1_pix_reg, ryc_pkg::WCB_R, ryc_pkg::WCB_G,
                                                ryc_pkg::WCB_B, ryc_pkg::CHROMA_OFFSET);
            s2_ctrl_reg   <= s1_ctrl_reg;
            s2_slot_reg   <= s1_slot_reg;
        end
    end

    // Estimate quotients by 1e9 and flag saturation
    always_ff @(posedge clk)
    begin
        if (stage_load[3])
        begin
            s3_q_y_reg  <= ryc_pkg::estimate(s2_acc_y_reg);
            s3_q_cr_reg <= ryc_pkg::estimate(s2_acc_cr_reg);
            s3_q_cb_reg <= ryc_pkg::estimate(s2_acc_cb_reg);
            s3_ctrl_reg <= s2_ctrl_reg;
            s3_slot_reg <= s2_slot_reg;
        end
    end

    // Correct the estimates and clamp
    always_ff @(posedge clk)
    begin
        if (stage_load[4])
        begin
            s4_y_reg    <= ryc_pkg::finish(s3_q_y_reg);
            s4_cr_reg   <= ryc_pkg::finish(s3_q_cr_reg);
            s4_cb_reg   <= ryc_pkg::finish(s3_q_cb_reg);
            s4_ctrl_reg <= s3_ctrl_reg;
            s4_slot_reg <= s3_slot_reg;
        end
    end

    // Store chroma on even rows, fetch it on odd rows; items pass here in order
    assign buf_wr_en = stage_load[5] && !s4_ctrl_reg.odd_row;
    assign buf_rd_en = stage_load[5] && s4_ctrl_reg.odd_row;

    ryc_ram #(
        .WIDTH (CHROMA_W),
        .DEPTH (MAX_WIDTH)
    ) u_chroma_line (
        .clk     (clk),
        .wr_en   (buf_wr_en),
        .wr_addr (s4_slot_reg),
        .wr_data ({s4_cr_reg, s4_cb_reg}),
        .rd_en   (buf_rd_en),
        .rd_addr (s4_slot_reg),
        .rd_data (buf_rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (stage_load[5])
        begin
            s5_y_reg    <= s4_y_reg;
            s5_cr_reg   <= s4_cr_reg;
            s5_cb_reg   <= s4_cb_reg;
            s5_ctrl_reg <= s4_ctrl_reg;
        end
    end

    // Average with the stored row on odd rows
    always_comb
    begin
        cr_sum = {1'b0, buf_rd_data[CHROMA_W-1:ryc_pkg::COMP_W]} + {1'b0, s5_cr_reg};
        cb_sum = {1'b0, buf_rd_data[ryc_pkg::COMP_W-1:0]} + {1'b0, s5_cb_reg};
        out_next.luma          = s5_y_reg;
        out_next.chroma_valid  = s5_ctrl_reg.odd_row;
        out_next.row_end       = s5_ctrl_reg.row_end;
        if (s5_ctrl_reg.odd_row)
        begin
            out_next.red_diff_avg  = cr_sum[ryc_pkg::COMP_W:1];
            out_next.blue_diff_avg = cb_sum[ryc_pkg::COMP_W:1];
        end
        else
        begin
            out_next.red_diff_avg  = '0;
            out_next.blue_diff_avg = '0;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (stage_load[NSTAGE])
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire
